// File: hw/rtl/ipg_pkg.sv
// Shared types and constants for the integer partition generator.
// No dependencies; imported by every module of the block but ipg_mem.
`timescale 1ns / 1ps

package ipg_pkg;

   localparam int PART_W = 6;   // width of one part and of the loaded number
   localparam int IDX_W  = 6;   // width of the top-slot index
   localparam int CALC_W = 8;   // signed working width for the x/y pair
   localparam int DATA_W = 8;   // byte-padded stream data width

   typedef enum logic {
      ACTION_START = 1'b0,
      ACTION_NEXT  = 1'b1
   } ipg_action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLR0,
      S_SET1,
      S_RD_LO,
      S_RD_HI,
      S_CALC,
      S_GROW,
      S_EMIT,
      S_FIN
   } ipg_state_type;

   typedef struct packed {
      logic [PART_W-1:0] part;
      logic              last_part;
      logic              finished;
   } ipg_result_type;

endpackage

// File: hw/rtl/ipg_mem.sv
// Part-slot memory: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module ipg_mem #(
   parameter int DEPTH  = 33,
   parameter int WIDTH  = 6,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ipg_seq.sv
// Sequencer: walks the ascending-composition step through the part memory
// and streams the slots out. Depends on ipg_pkg.
`timescale 1ns / 1ps

module ipg_seq
   import ipg_pkg::*;
#(
   parameter int MAX_N  = 32,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_action,
   input  logic [PART_W-1:0] req_value,
   output logic              req_ready,
   input  logic              out_free,
   output logic              push_valid,
   output ipg_result_type    push,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [PART_W-1:0] mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [PART_W-1:0] mem_rd_data
);

   localparam int CNT_W = $clog2(MAX_N + 2);

   ipg_state_type             state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [PART_W-1:0]         n_ff, n_in;
   logic signed [CALC_W-1:0]  x_ff, x_in;
   logic signed [CALC_W-1:0]  y_ff, y_in;
   logic [ADDR_W-1:0]         k_ff, k_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      pend_ff, pend_in;
   logic                      pend_last_ff, pend_last_in;

   logic [PART_W-1:0]         n_sat;
   logic signed [CALC_W-1:0]  rd_ext;
   logic signed [CALC_W-1:0]  sum_xy;
   logic                      grow_go;
   logic                      move;
   logic                      issue_done;
   logic                      issue;
   logic                      idx_dead;

   assign n_sat      = (32'(req_value) > MAX_N) ? PART_W'(MAX_N) : req_value;
   assign rd_ext     = $signed({{(CALC_W-PART_W){1'b0}}, mem_rd_data});
   assign sum_xy     = x_ff + y_ff;
   assign grow_go    = (x_ff <= y_ff) && (32'(k_ff) < MAX_N);
   assign move       = pend_ff && out_free;
   assign issue_done = 32'(cnt_ff) > 32'(k_ff);
   assign issue      = !issue_done && (!pend_ff || move);
   assign idx_dead   = (idx_ff == '0) || (32'(idx_ff) > MAX_N);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACTION_START) begin
                  state_in = S_CLR0;
               end else if (idx_dead) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_RD_LO;
               end
            end
         end
         S_CLR0:  state_in = S_SET1;
         S_SET1:  state_in = S_IDLE;
         S_RD_LO: state_in = S_RD_HI;
         S_RD_HI: state_in = S_CALC;
         S_CALC:  state_in = S_GROW;
         S_GROW: begin
            if (!grow_go) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (issue_done && (!pend_ff || move)) begin
               state_in = S_IDLE;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = '0;
      mem_wr_data  = '0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      idx_in       = idx_ff;
      n_in         = n_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff && !move;
      pend_last_in = pend_last_ff;
      // pending slot drains into the output stage whenever it frees up
      push_valid     = move;
      push.part      = mem_rd_data;
      push.last_part = pend_last_ff;
      push.finished  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_action == ACTION_START)) begin
               n_in   = n_sat;
               idx_in = (n_sat == '0) ? '0 : IDX_W'(1);
            end
         end
         S_CLR0: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = '0;
         end
         S_SET1: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = ADDR_W'(1);
            mem_wr_data = n_ff;
         end
         S_RD_LO: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(idx_ff - IDX_W'(1));
         end
         S_RD_HI: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(idx_ff);
            x_in        = rd_ext + CALC_W'(1);
         end
         S_CALC: begin
            y_in = rd_ext - CALC_W'(1);
            k_in = ADDR_W'(idx_ff - IDX_W'(1));
         end
         S_GROW: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = k_ff;
            if (grow_go) begin
               mem_wr_data = x_ff[PART_W-1:0];
               y_in        = y_ff - x_ff;
               k_in        = k_ff + ADDR_W'(1);
            end else begin
               mem_wr_data = sum_xy[PART_W-1:0];
               idx_in      = IDX_W'(k_ff);
               cnt_in      = '0;
            end
         end
         S_EMIT: begin
            if (issue) begin
               mem_rd_en    = 1'b1;
               mem_rd_addr  = cnt_ff[ADDR_W-1:0];
               cnt_in       = cnt_ff + CNT_W'(1);
               pend_in      = 1'b1;
               pend_last_in = (32'(cnt_ff) == 32'(k_ff));
            end
         end
         S_FIN: begin
            if (out_free) begin
               push_valid     = 1'b1;
               push.part      = '0;
               push.last_part = 1'b0;
               push.finished  = 1'b1;
               idx_in         = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      k_ff         <= k_in;
      cnt_ff       <= cnt_in;
      pend_last_ff <= pend_last_in;
   end

endmodule

// File: hw/rtl/ipg_out.sv
// Result register stage driving the rsp stream. Depends on ipg_pkg.
`timescale 1ns / 1ps

module ipg_out
   import ipg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  ipg_result_type    push,
   output logic              free,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tuser
);

   logic           valid_ff, valid_in;
   ipg_result_type res_ff, res_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      res_in   = res_ff;
      if (push_valid && free) begin
         valid_in = 1'b1;
         res_in   = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(DATA_W-PART_W){1'b0}}, res_ff.part};
   assign rsp_tlast  = res_ff.last_part;
   assign rsp_tuser  = res_ff.finished;

endmodule

// File: hw/rtl/integer_partition_generator.sv
// Top level of the integer partition generator.
// Depends on ipg_pkg, ipg_mem, ipg_seq and ipg_out.
`timescale 1ns / 1ps

// Generates the partitions of n, one per next item, in ascending-composition
// order (all ones first, the single part n last). A start transfer
// (req_tuser = 0) loads n from req_tdata, saturated to MAX_N, and returns
// nothing. Each next transfer (req_tuser = 1) advances one step and returns
// the parts of one partition in ascending order, one per rsp transfer, with
// rsp_tlast on the final part. Once the partitions run out, or after a start
// with n = 0, a next transfer returns a single transfer with rsp_tuser set and
// zero data. A start is accepted and then writes two slots, clearing slot 0
// and setting slot 1 to n. A next item is accepted, then reads two slots,
// takes one setup step and writes one memory slot for each slot from
// index - 1 up to k, where index is the top slot before the step and k the
// top slot after it; then it reads and emits the parts one at a time,
// stalling while the output stage is not free, and hands the last part over.
// A finished answer is accepted, then handed over once the output is free.
// Through the part memory, with one write port and one read port, every slot
// is written and read back one per cycle, reads stalling with the output.
// One item is handled at a time; the next is accepted while the last result
// of the previous one still waits in the output register.
module integer_partition_generator
   import ipg_pkg::*;
#(
   parameter int MAX_N = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [5:0] value, [7:6] zero
   input  logic              req_tuser,   // [0] action (0 start, 1 next)
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [5:0] part, [7:6] zero
   output logic              rsp_tlast,   // last_part
   output logic              rsp_tuser    // [0] finished
);

   // slot MAX_N is the highest slot the step can write
   localparam int DEPTH  = MAX_N + 1;
   localparam int ADDR_W = $clog2(DEPTH);

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [PART_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [PART_W-1:0] mem_rd_data;

   logic              out_free;
   logic              push_valid;
   ipg_result_type    push;

   // part slots; every slot is written before it is read, so no reset
   ipg_mem #(
      .DEPTH  (DEPTH),
      .WIDTH  (PART_W),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // step sequencer: reads the top two slots, grows the composition,
   // then streams slots 0..k toward the output stage
   ipg_seq #(
      .MAX_N  (MAX_N),
      .ADDR_W (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_action  (req_tuser),
      .req_value   (req_tdata[PART_W-1:0]),
      .req_ready   (req_tready),
      .out_free    (out_free),
      .push_valid  (push_valid),
      .push        (push),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // output register: holds a result while the sink stalls
   ipg_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push       (push),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: hw/rtl/ipg_checker.sv
// Port-level checks for the integer partition generator, bound to the top.
// Depends on ipg_pkg and integer_partition_generator.
`timescale 1ns / 1ps

module ipg_checker
   import ipg_pkg::*;
#(
   parameter int MAX_N = 32
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic              rsp_tlast,
   input logic              rsp_tuser
);

   // a finished transfer carries no part and no last mark
   a_fin_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (!rsp_tlast && (rsp_tdata == '0)))
      else $error("finished transfer carries part data");

   // every real part lies in 1..MAX_N
   a_part_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         ((rsp_tdata != '0) && (32'(rsp_tdata) <= MAX_N)))
      else $error("part out of range");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   // nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind integer_partition_generator ipg_checker #(
   .MAX_N (MAX_N)
) u_ipg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
